FILE: hw/rtl/oepf_pkg.sv
// oepf_pkg: shared constants, register indexes and control structs for the
// one-euro point filter core. No dependencies; used by oepf_alu and the top level.
`default_nettype none

package oepf_pkg;

	// configuration port
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DERIVATIVE_CUTOFF = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MINIMUM_CUTOFF    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_COEFFICIENT = 2'd3;

	localparam logic [CFG_W-1:0] SAMPLE_PERIOD_RST     = 16'd328;
	localparam logic [CFG_W-1:0] DERIVATIVE_CUTOFF_RST = 16'd256;
	localparam logic [CFG_W-1:0] MINIMUM_CUTOFF_RST    = 16'd256;
	localparam logic [CFG_W-1:0] SPEED_COEFFICIENT_RST = 16'd655;

	// 2*pi in Q3.28, and the shift that brings cutoff*dt*2pi back to Q.16
	localparam int              TWO_PI_W   = 31;
	localparam logic [TWO_PI_W-1:0] TWO_PI_Q28 = 31'd1686629713;
	localparam int              R_SHIFT    = 44 - TWO_PI_W;
	localparam int              R_W        = 35;
	localparam int              ALPHA_W    = 16;

	// shared shift/add/subtract unit
	localparam int   CNT_W  = 6;
	localparam logic OP_MUL = 1'b0;
	localparam logic OP_DIV = 1'b1;

	typedef struct packed {
		logic             start;
		logic             op;
		logic [CNT_W-1:0] steps;
	} alu_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} alu_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/oepf_alu.sv
// oepf_alu: one adder used bit-serially, as a right-shifting multiplier
// (floor(b*a / 2^steps)) or as a restoring divider. Depends on oepf_pkg.
`default_nettype none

module oepf_alu #(
	parameter int BW = 48,
	parameter int QW = 31
) (
	input  logic                clk,
	input  logic                arst_n,
	input  oepf_pkg::alu_cmd_t  cmd,
	input  logic [BW-1:0]       opnd_b,
	input  logic [QW-1:0]       a_init,
	input  logic [BW-1:0]       r_init,
	output oepf_pkg::alu_stat_t stat,
	output logic [BW-1:0]       acc,
	output logic [QW-1:0]       quo
);

	logic [BW-1:0]              acc_q;
	logic [QW-1:0]              a_q;
	logic [oepf_pkg::CNT_W-1:0] cnt_q;
	logic                       op_q;
	logic                       busy_q;
	logic                       done_q;

	logic          is_div;
	logic [BW:0]   shl_rem;
	logic [BW+1:0] opa;
	logic [BW+1:0] opb;
	logic [BW+1:0] sum;
	logic          take;

	assign is_div  = (op_q == oepf_pkg::OP_DIV);
	// divide: partial remainder shifted left, next dividend bit appended
	assign shl_rem = {acc_q, a_q[QW-1]};

	always_comb begin
		if (is_div) begin
			opa = {1'b0, shl_rem};
			opb = ~{2'b00, opnd_b};
		end else begin
			opa = {2'b00, acc_q};
			opb = a_q[0] ? {2'b00, opnd_b} : '0;
		end
		sum  = opa + opb + (BW+2)'(is_div);
		take = ~sum[BW+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= oepf_pkg::OP_MUL;
		end else begin
			done_q <= busy_q && (cnt_q == oepf_pkg::CNT_W'(1)) && !cmd.start;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= cmd.steps;
				op_q   <= cmd.op;
			end else if (busy_q) begin
				cnt_q <= cnt_q - oepf_pkg::CNT_W'(1);
				if (cnt_q == oepf_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_q <= (cmd.op == oepf_pkg::OP_DIV) ? r_init : '0;
			a_q   <= a_init;
		end else if (busy_q) begin
			if (is_div) begin
				acc_q <= take ? sum[BW-1:0] : shl_rem[BW-1:0];
				a_q   <= {a_q[QW-2:0], take};
			end else begin
				// nested halving keeps the floor exact
				acc_q <= sum[BW:1];
				a_q   <= a_q >> 1;
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign acc       = acc_q;
	assign quo       = a_q;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("oepf_alu: done held longer than one cycle");

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !busy_q)
		else $error("oepf_alu: start issued while busy");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && is_div) |-> (acc_q < opnd_b))
		else $error("oepf_alu: partial remainder not below divisor");

endmodule

`default_nettype wire

FILE: hw/rtl/one_euro_point_filter_core.sv
// one_euro_point_filter_core: two-axis one-euro filter, fixed point, run by a
// sequencer over one shared serial unit. Depends on oepf_pkg and oepf_alu.
//
//  channel  dir  handshake              payload
//  cfg      in   cfg_write              cfg_index, cfg_data
//  in       in   in_valid / in_ready    x_in, y_in
//  out      out  out_valid / out_ready  x_out, y_out
//
// One point runs through 17 serial steps on the shared unit from accept to result;
// an axis whose velocity saturates skips its divide.
// in_ready is high only while the sequencer is idle; a result waiting on
// out_ready does not block the next accept, only the next result.
// Reset clears all filter state to zero and loads the register defaults.
`default_nettype none

module one_euro_point_filter_core #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [oepf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [oepf_pkg::CFG_W-1:0]       cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [COORD_BITS-1:0]     x_in,
	input  logic signed [COORD_BITS-1:0]     y_in,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [COORD_BITS-1:0]     x_out,
	output logic signed [COORD_BITS-1:0]     y_out
);

	localparam int C   = COORD_BITS;
	localparam int F   = FRAC_BITS;
	localparam int S   = C + F;
	localparam int BW  = (S + 1 > 48) ? S + 1 : 48;
	localparam int QW  = (S - 1 > oepf_pkg::TWO_PI_W) ? S - 1 : oepf_pkg::TWO_PI_W;
	localparam int DW  = S + 16;
	localparam int SHL = (F < 16) ? 16 - F : 0;
	localparam int SHR = (F > 16) ? F - 16 : 0;
	localparam logic [S-1:0] VMAX = {1'b0, {(S-1){1'b1}}};

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_PD   = 4'd1;
	localparam logic [3:0] ST_RD   = 4'd2;
	localparam logic [3:0] ST_AD   = 4'd3;
	localparam logic [3:0] ST_VD   = 4'd4;
	localparam logic [3:0] ST_BS   = 4'd5;
	localparam logic [3:0] ST_CO   = 4'd6;
	localparam logic [3:0] ST_PX   = 4'd7;
	localparam logic [3:0] ST_RX   = 4'd8;
	localparam logic [3:0] ST_AX   = 4'd9;
	localparam logic [3:0] ST_BX   = 4'd10;
	localparam logic [3:0] ST_OUT  = 4'd11;

	// configuration
	logic [15:0] dt_q, dcut_q, mcut_q, beta_q;
	logic [15:0] dt_eff;

	// control and filter state
	logic [3:0]   state_q;
	logic         issued_q;
	logic         ax_q;
	logic         out_valid_q;
	logic [C-1:0] last_x_q, last_y_q;
	logic [S-1:0] sm_x_q, sm_y_q;
	logic [S-1:0] spd_x_q, spd_y_q;

	// per-item working registers
	logic [C-1:0]              x_q, y_q;
	logic [BW-1:0]             w_q;
	logic [oepf_pkg::R_W-1:0]  r_q;
	logic [15:0]               ad_q, aa_q;
	logic [S-1:0]              vel_q;
	logic [31:0]               cut_q;
	logic [C-1:0]              x_out_q, y_out_q;

	// shared unit
	oepf_pkg::alu_cmd_t  cmd;
	oepf_pkg::alu_stat_t stat;
	logic [BW-1:0]       b_op, r_init, acc;
	logic [QW-1:0]       a_init, quo;
	logic                done;

	// current axis
	logic [C-1:0] raw_c, last_c;
	logic [S-1:0] sm_c, spd_c;

	// velocity
	logic [C:0]    diff, diff_n;
	logic          dneg;
	logic [C-1:0]  dmag;
	logic [DW-1:0] dvd;
	logic [16:0]   rinit_v;
	logic          vsat;
	logic [S-1:0]  vm_sel, vel_v;

	// blend
	logic [S-1:0] b_old, b_tgt, b_mag, b_new;
	logic [S:0]   b_d, b_nd, b_sum;
	logic         b_neg;

	// cutoff
	logic [S-1:0]  spd_n;
	logic [S-2:0]  svm;
	logic [BW-1:0] add_w;
	logic [BW:0]   cut_sum;
	logic          cut_sat;
	logic [31:0]   cut_src;

	logic is_op;

	function automatic logic [C-1:0] to_coord(input logic [S-1:0] v);
		logic adj;
		// floor, then step up for negative values with a fraction: truncate toward zero
		adj = v[S-1] & (|v[F-1:0]);
		return v[S-1:F] + C'(adj);
	endfunction

	assign dt_eff = (dt_q == 16'd0) ? 16'd1 : dt_q;

	assign raw_c  = ax_q ? y_q : x_q;
	assign last_c = ax_q ? last_y_q : last_x_q;
	assign sm_c   = ax_q ? sm_y_q : sm_x_q;
	assign spd_c  = ax_q ? spd_y_q : spd_x_q;

	// velocity = |diff| * 2^(16+F) / dt; saturate when the quotient would pass S-1 bits
	always_comb begin
		diff    = {raw_c[C-1], raw_c} - {last_c[C-1], last_c};
		diff_n  = -diff;
		dneg    = diff[C];
		dmag    = dneg ? diff_n[C-1:0] : diff[C-1:0];
		dvd     = DW'(dmag) << (16 + F);
		rinit_v = dvd[DW-1:S-1];
		vsat    = (rinit_v >= {1'b0, dt_eff});
		vm_sel  = vsat ? VMAX : {1'b0, quo[S-2:0]};
		vel_v   = dneg ? -vm_sel : vm_sel;
	end

	always_comb begin
		b_old = (state_q == ST_BX) ? sm_c : spd_c;
		b_tgt = (state_q == ST_BX) ? {raw_c, {F{1'b0}}} : vel_q;
		b_d   = {b_tgt[S-1], b_tgt} - {b_old[S-1], b_old};
		b_nd  = -b_d;
		b_neg = b_d[S];
		b_mag = b_neg ? b_nd[S-1:0] : b_d[S-1:0];
		b_sum = b_neg ? ({b_old[S-1], b_old} - {1'b0, acc[S-1:0]})
		              : ({b_old[S-1], b_old} + {1'b0, acc[S-1:0]});
		b_new = b_sum[S-1:0];
	end

	always_comb begin
		spd_n   = -spd_c;
		svm     = spd_c[S-1] ? spd_n[S-2:0] : spd_c[S-2:0];
		add_w   = acc >> SHR;
		cut_sum = {1'b0, add_w} + (BW+1)'({mcut_q, 8'b0});
		cut_sat = |cut_sum[BW:32];
		cut_src = (state_q == ST_PD) ? {8'b0, dcut_q, 8'b0} : cut_q;
	end

	assign is_op = (state_q != ST_IDLE) && (state_q != ST_OUT);
	assign done  = stat.done;

	always_comb begin
		cmd.op    = oepf_pkg::OP_MUL;
		cmd.steps = oepf_pkg::CNT_W'(oepf_pkg::ALPHA_W);
		b_op      = '0;
		a_init    = '0;
		r_init    = '0;
		case (state_q)
			ST_PD, ST_PX: begin
				b_op   = BW'({cut_src, 16'b0});
				a_init = QW'(dt_eff);
			end
			ST_RD, ST_RX: begin
				cmd.steps = oepf_pkg::CNT_W'(oepf_pkg::TWO_PI_W);
				b_op      = w_q;
				a_init    = QW'(oepf_pkg::TWO_PI_Q28);
			end
			ST_AD, ST_AX: begin
				cmd.op = oepf_pkg::OP_DIV;
				b_op   = BW'(r_q) + (BW'(1) << 16);
				r_init = BW'(r_q);
			end
			ST_VD: begin
				cmd.op    = oepf_pkg::OP_DIV;
				cmd.steps = oepf_pkg::CNT_W'(S - 1);
				b_op      = BW'(dt_eff);
				r_init    = BW'(rinit_v);
				a_init    = QW'(dvd[S-2:0]) << (QW - (S - 1));
			end
			ST_BS: begin
				b_op   = BW'(b_mag);
				a_init = QW'(ad_q);
			end
			ST_BX: begin
				b_op   = BW'(b_mag);
				a_init = QW'(aa_q);
			end
			ST_CO: begin
				b_op   = BW'(svm) << SHL;
				a_init = QW'(beta_q);
			end
			default: begin
			end
		endcase
		cmd.start = is_op && !issued_q && !((state_q == ST_VD) && vsat);
	end

	oepf_alu #(
		.BW(BW),
		.QW(QW)
	) u_alu (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.opnd_b(b_op),
		.a_init(a_init),
		.r_init(r_init),
		.stat  (stat),
		.acc   (acc),
		.quo   (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q   <= oepf_pkg::SAMPLE_PERIOD_RST;
			dcut_q <= oepf_pkg::DERIVATIVE_CUTOFF_RST;
			mcut_q <= oepf_pkg::MINIMUM_CUTOFF_RST;
			beta_q <= oepf_pkg::SPEED_COEFFICIENT_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				oepf_pkg::REG_SAMPLE_PERIOD:     dt_q   <= cfg_data;
				oepf_pkg::REG_DERIVATIVE_CUTOFF: dcut_q <= cfg_data;
				oepf_pkg::REG_MINIMUM_CUTOFF:    mcut_q <= cfg_data;
				oepf_pkg::REG_SPEED_COEFFICIENT: beta_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issued_q    <= 1'b0;
			ax_q        <= 1'b0;
			out_valid_q <= 1'b0;
			last_x_q    <= '0;
			last_y_q    <= '0;
			sm_x_q      <= '0;
			sm_y_q      <= '0;
			spd_x_q     <= '0;
			spd_y_q     <= '0;
		end else begin
			if (cmd.start) begin
				issued_q <= 1'b1;
			end else if (done) begin
				issued_q <= 1'b0;
			end
			if (out_valid_q && out_ready && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						ax_q    <= 1'b0;
						state_q <= ST_PD;
					end
				end
				ST_PD: if (done) state_q <= ST_RD;
				ST_RD: if (done) state_q <= ST_AD;
				ST_AD: if (done) state_q <= ST_VD;
				ST_VD: if (done || vsat) state_q <= ST_BS;
				ST_BS: begin
					if (done) begin
						if (ax_q) spd_y_q <= b_new;
						else      spd_x_q <= b_new;
						state_q <= ST_CO;
					end
				end
				ST_CO: if (done) state_q <= ST_PX;
				ST_PX: if (done) state_q <= ST_RX;
				ST_RX: if (done) state_q <= ST_AX;
				ST_AX: if (done) state_q <= ST_BX;
				ST_BX: begin
					if (done) begin
						if (ax_q) begin
							sm_y_q   <= b_new;
							last_y_q <= raw_c;
							state_q  <= ST_OUT;
						end else begin
							sm_x_q   <= b_new;
							last_x_q <= raw_c;
							ax_q     <= 1'b1;
							state_q  <= ST_VD;
						end
					end
				end
				ST_OUT: begin
					// hold until the previous result beat has left
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					x_q <= x_in;
					y_q <= y_in;
				end
			end
			ST_PD, ST_PX: if (done) w_q <= acc;
			ST_RD, ST_RX: if (done) r_q <= acc[oepf_pkg::R_SHIFT +: oepf_pkg::R_W];
			ST_AD: if (done) ad_q <= quo[oepf_pkg::ALPHA_W-1:0];
			ST_AX: if (done) aa_q <= quo[oepf_pkg::ALPHA_W-1:0];
			ST_VD: if (done || vsat) vel_q <= vel_v;
			ST_CO: if (done) cut_q <= cut_sat ? 32'hFFFF_FFFF : cut_sum[31:0];
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					x_out_q <= to_coord(sm_x_q);
					y_out_q <= to_coord(sm_y_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign x_out     = x_out_q;
	assign y_out     = y_out_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (!in_ready && !stat.busy))
		else $error("one_euro_point_filter_core: sequencer did not leave idle on accept");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(x_out) && $stable(y_out)))
		else $error("one_euro_point_filter_core: result beat changed while waiting");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !stat.busy)
		else $error("one_euro_point_filter_core: shared unit busy while ready");

endmodule

`default_nettype wire

FILE: bench/one_euro_point_filter_core_test.sv
`timescale 1ns / 100ps
// one_euro_point_filter_core_test: self-checking bench for the two-axis one-euro filter.
// Drives raw points and register writes, predicts each filtered point in a local
// tracker and compares it field by field. Depends on oepf_pkg and the core.

module one_euro_point_filter_core_test;

	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 123;
	localparam int TWO_PI_FRAC = 28;
	localparam bit [63:0] TWO_PI_WIDE = 64'(oepf_pkg::TWO_PI_Q28);
	localparam bit [63:0] SPEED_MAX   = 64'h7FFF_FFFF;

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
	} point_t;

	// Tracks both axes of the filter and the points still owed by the core.
	class point_smoother;
		bit [15:0] period_q16, dcut_q8, mincut_q8, beta_q16;
		longint prev_raw [2];
		longint pos_q16 [2];
		longint vel_q16 [2];
		point_t points_due [$];
		int faults;

		function void restart();
			period_q16 = oepf_pkg::SAMPLE_PERIOD_RST;
			dcut_q8 = oepf_pkg::DERIVATIVE_CUTOFF_RST;
			mincut_q8 = oepf_pkg::MINIMUM_CUTOFF_RST;
			beta_q16 = oepf_pkg::SPEED_COEFFICIENT_RST;
			for (int a = 0; a < 2; a++) begin
				prev_raw[a] = 0;
				pos_q16[a] = 0;
				vel_q16[a] = 0;
			end
			points_due.delete();
			faults = 0;
		endfunction

		function void set_reg(logic [oepf_pkg::CFG_IDX_W-1:0] idx,
				logic [oepf_pkg::CFG_W-1:0] val);
			case (idx)
				oepf_pkg::REG_SAMPLE_PERIOD:     period_q16 = val;
				oepf_pkg::REG_DERIVATIVE_CUTOFF: dcut_q8 = val;
				oepf_pkg::REG_MINIMUM_CUTOFF:    mincut_q8 = val;
				oepf_pkg::REG_SPEED_COEFFICIENT: beta_q16 = val;
				default: ;
			endcase
		endfunction

		// smoothing factor r/(r+1) in Q0.16, r = 2pi * cutoff(Q16.16) * dt(Q0.16)
		function bit [63:0] alpha_for(bit [63:0] cutoff, bit [63:0] dt);
			bit [63:0] p, r;
			p = cutoff * dt;
			r = ((p >> 16) * TWO_PI_WIDE + (((p & 64'hFFFF) * TWO_PI_WIDE) >> 16)) >> TWO_PI_FRAC;
			return (r << 16) / (r + 64'd65536);
		endfunction

		function longint blend_toward(longint old, longint target, bit [63:0] a);
			longint d;
			bit [63:0] mag, q;
			d = target - old;
			mag = (d < 0) ? -d : d;
			q = (mag >> 16) * a + (((mag & 64'hFFFF) * a) >> 16);
			return (d < 0) ? old - longint'(q) : old + longint'(q);
		endfunction

		function logic signed [15:0] step_axis(int ax, longint raw);
			bit [63:0] dt, mag, num, ip, rem, vm, svm, beta, add, cutoff;
			longint diff, vel, res;
			dt = (period_q16 == 0) ? 64'd1 : 64'(period_q16);
			diff = raw - prev_raw[ax];
			mag = (diff < 0) ? -diff : diff;
			num = mag << 16;
			ip = num / dt;
			rem = num % dt;
			if (ip >= 64'd32768)
				vm = SPEED_MAX;
			else
				vm = (ip << 16) + ((rem << 16) / dt);
			if (vm > SPEED_MAX)
				vm = SPEED_MAX;
			vel = (diff < 0) ? -longint'(vm) : longint'(vm);
			vel_q16[ax] = blend_toward(vel_q16[ax], vel, alpha_for(64'({dcut_q8, 8'h00}), dt));

			svm = (vel_q16[ax] < 0) ? -vel_q16[ax] : vel_q16[ax];
			beta = 64'(beta_q16);
			add = beta * (svm >> 16) + ((beta * (svm & 64'hFFFF)) >> 16);
			cutoff = 64'({mincut_q8, 8'h00}) + add;
			if (cutoff > 64'hFFFF_FFFF)
				cutoff = 64'hFFFF_FFFF;
			pos_q16[ax] = blend_toward(pos_q16[ax], raw * 65536, alpha_for(cutoff, dt));
			prev_raw[ax] = raw;

			res = pos_q16[ax] / 65536;
			if (res > 32767)
				res = 32767;
			if (res < -32768)
				res = -32768;
			return res[15:0];
		endfunction

		function void predict_point(logic signed [15:0] x, logic signed [15:0] y);
			point_t p;
			p.x = step_axis(0, longint'(x));
			p.y = step_axis(1, longint'(y));
			points_due.push_back(p);
		endfunction

		function void check_point(logic signed [15:0] x, logic signed [15:0] y);
			point_t want;
			if (points_due.size() == 0) begin
				$display("%0t unexpected point: expected none, got (%0d, %0d)", $time, x, y);
				faults++;
			end else begin
				want = points_due.pop_front();
				if (x !== want.x) begin
					$display("%0t x_out: expected %0d, got %0d", $time, want.x, x);
					faults++;
				end
				if (y !== want.y) begin
					$display("%0t y_out: expected %0d, got %0d", $time, want.y, y);
					faults++;
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [oepf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [oepf_pkg::CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [15:0] x_in = '0;
	logic signed [15:0] y_in = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] x_out;
	logic signed [15:0] y_out;

	bit gaps_on = 1'b0;
	point_smoother smoother;

	int dir_x [22] = '{0, 0, 32767, 32767, 32767, -32768, -32768, -1, 1, 0, 100,
		150, 200, 250, 250, 250, -21846, 21845, 16384, -16385, 0, 0};
	int dir_y [22] = '{0, 0, -32768, -32768, -32768, 32767, 32767, 1, -1, 0, -100,
		-160, -220, -280, -280, -280, 21845, -21846, -16384, 16383, 0, 0};

	one_euro_point_filter_core #(
		.COORD_BITS(16),
		.FRAC_BITS(16)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.x_in(x_in),
		.y_in(y_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.x_out(x_out),
		.y_out(y_out)
	);

	always #1 clk = ~clk;

	function automatic int clamp_coord(int v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	task automatic offer_point(input logic signed [15:0] x, input logic signed [15:0] y);
		in_valid <= 1'b1;
		x_in <= x;
		y_in <= y;
		do @(posedge clk); while (!in_ready);
		smoother.predict_point(x, y);
	endtask

	task automatic pause_input(input int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic program_regs(input logic [oepf_pkg::CFG_W-1:0] period,
			input logic [oepf_pkg::CFG_W-1:0] dcut,
			input logic [oepf_pkg::CFG_W-1:0] mincut,
			input logic [oepf_pkg::CFG_W-1:0] beta);
		logic [oepf_pkg::CFG_IDX_W-1:0] idx [4];
		logic [oepf_pkg::CFG_W-1:0] val [4];
		idx = '{oepf_pkg::REG_SAMPLE_PERIOD, oepf_pkg::REG_DERIVATIVE_CUTOFF,
			oepf_pkg::REG_MINIMUM_CUTOFF, oepf_pkg::REG_SPEED_COEFFICIENT};
		val = '{period, dcut, mincut, beta};
		for (int i = 0; i < 4; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
			smoother.set_reg(idx[i], val[i]);
		end
		cfg_write <= 1'b0;
	endtask

	// Mostly smooth tracks with random speed, plus jumps, holds and stray points.
	task automatic run_phase(input int count);
		int cx, cy, vx, vy, run_left;
		logic signed [15:0] nx, ny;
		cx = 0;
		cy = 0;
		vx = 0;
		vy = 0;
		run_left = 0;
		for (int n = 0; n < count; n++) begin
			if (run_left == 0) begin
				run_left = $urandom_range(4, 30);
				vx = int'($urandom_range(0, 600)) - 300;
				vy = int'($urandom_range(0, 600)) - 300;
				case ($urandom_range(0, 7))
					0: begin
						nx = 16'($urandom);
						ny = 16'($urandom);
						cx = int'(nx);
						cy = int'(ny);
					end
					1: begin
						vx = 0;
						vy = 0;
					end
					default: ;
				endcase
			end
			run_left--;
			if ($urandom_range(0, 15) == 0) begin
				nx = 16'($urandom);
				ny = 16'($urandom);
			end else begin
				cx = clamp_coord(cx + vx + int'($urandom_range(0, 6)) - 3);
				cy = clamp_coord(cy + vy + int'($urandom_range(0, 6)) - 3);
				nx = cx[15:0];
				ny = cy[15:0];
			end
			if (gaps_on && $urandom_range(0, 5) == 0)
				pause_input($urandom_range(1, 14));
			offer_point(nx, ny);
		end
		in_valid <= 1'b0;
	endtask

	initial begin : stimulus
		logic [oepf_pkg::CFG_W-1:0] p, d, m, b;
		int waited;
		smoother = new();
		smoother.restart();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int phase = 0; phase < PHASES; phase++) begin
			// registers change only while the core is idle
			while (smoother.points_due.size() != 0) @(posedge clk);
			repeat (4) @(posedge clk);
			case (phase)
				0: begin
					p = oepf_pkg::SAMPLE_PERIOD_RST;
					d = oepf_pkg::DERIVATIVE_CUTOFF_RST;
					m = oepf_pkg::MINIMUM_CUTOFF_RST;
					b = oepf_pkg::SPEED_COEFFICIENT_RST;
				end
				1: begin
					p = 16'd0;
					d = 16'hFFFF;
					m = 16'hFFFF;
					b = 16'hFFFF;
				end
				2: begin
					p = 16'hFFFF;
					d = 16'd0;
					m = 16'd0;
					b = 16'd0;
				end
				3: begin
					p = 16'd1;
					d = 16'd256;
					m = 16'd0;
					b = 16'hFFFF;
				end
				4: begin
					p = 16'hFFFF;
					d = 16'hFFFF;
					m = 16'hFFFF;
					b = 16'hFFFF;
				end
				5: begin
					p = 16'd655;
					d = 16'd256;
					m = 16'd128;
					b = 16'd2000;
				end
				default: begin
					p = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
					d = 16'($urandom);
					m = 16'($urandom);
					b = 16'($urandom);
				end
			endcase
			program_regs(p, d, m, b);
			gaps_on = !(phase == 2 || phase == 5 || phase == PHASES - 1);
			if (phase == 0)
				for (int k = 0; k < 22; k++)
					offer_point(dir_x[k][15:0], dir_y[k][15:0]);
			run_phase(PHASE_ITEMS);
		end

		waited = 0;
		while (smoother.points_due.size() != 0 && waited < 100000) begin
			waited++;
			@(posedge clk);
		end
		repeat (400) @(posedge clk);
		if (smoother.faults == 0 && smoother.points_due.size() == 0)
			$display("tb: success");
		else begin
			if (smoother.points_due.size() != 0)
				$display("%0t %0d filtered points never arrived", $time,
					smoother.points_due.size());
			$display("tb: failure");
		end
		$finish;
	end

	initial begin : result_sink
		int stall_left;
		int points_taken;
		bit held;
		stall_left = 0;
		points_taken = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				smoother.check_point(x_out, y_out);
				points_taken++;
			end
			// hold off long enough that the core backs up and drops in_ready
			if (!held && points_taken == 160) begin
				held = 1'b1;
				stall_left = 3000;
			end else if (stall_left == 0 && gaps_on && $urandom_range(0, 11) == 0)
				stall_left = $urandom_range(1, 14);
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else
				out_ready <= 1'b1;
		end
	end

	initial begin : watchdog
		#8_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
